/* rtl/irt_pkg.sv */
`default_nettype none

package irt_pkg;

    // Value and symbol-set sizing
    localparam int VALUE_WIDTH = 32;
    localparam int MAX_SYMBOLS = 32;
    localparam int SYM_WORDS   = 4;
    localparam int SYM_SLOTS   = SYM_WORDS * 8;
    localparam int RADIX_LIMIT = (MAX_SYMBOLS < SYM_SLOTS) ? MAX_SYMBOLS : SYM_SLOTS;
    localparam int RADIX_W     = 6;
    localparam int DIGIT_W     = $clog2(SYM_SLOTS);
    localparam int MAX_DIGITS  = VALUE_WIDTH;
    localparam int ND_W        = $clog2(MAX_DIGITS + 1);

    // Divider: bits retired per cycle must divide the value width
    localparam int DIV_BITS    = (VALUE_WIDTH % 4 == 0) ? 4 :
                                 ((VALUE_WIDTH % 2 == 0) ? 2 : 1);
    localparam int DIV_CYCLES  = VALUE_WIDTH / DIV_BITS;
    localparam int DIV_CNT_W   = $clog2(DIV_CYCLES + 1);

    // Configuration port
    localparam int REG_COUNT   = 5;
    localparam int REG_IDX_W   = $clog2(REG_COUNT);
    localparam int ADDR_LSB    = 3;
    localparam int PADDR_W     = REG_IDX_W + ADDR_LSB;
    localparam int PDATA_W     = 64;

    localparam logic [REG_IDX_W-1:0] REG_RADIX = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_SYM0  = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_SYM1  = REG_IDX_W'(2);
    localparam logic [REG_IDX_W-1:0] REG_SYM2  = REG_IDX_W'(3);
    localparam logic [REG_IDX_W-1:0] REG_SYM3  = REG_IDX_W'(4);

    // Reset values of the registers
    localparam logic [RADIX_W-1:0] RADIX_RESET = RADIX_W'(10);
    localparam logic [63:0] SYM0_RESET = 64'h3837_3635_3433_3231;
    localparam logic [63:0] SYM1_RESET = 64'h0000_0000_0000_3938;
    localparam logic [63:0] SYM2_RESET = 64'h0;
    localparam logic [63:0] SYM3_RESET = 64'h0;

    // Characters
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_NUL   = 8'h00;

    typedef logic [SYM_SLOTS-1:0][7:0] sym_table_t;

    // Configuration seen by the datapath
    typedef struct packed {
        logic               wr;
        logic [RADIX_W-1:0] radix;
        sym_table_t         syms;
    } cfg_t;

    // Symbol-set checker status
    typedef struct packed {
        logic busy;
        logic set_ok;
    } chk_stat_t;

    // Divider command and status
    typedef struct packed {
        logic                   start;
        logic [VALUE_WIDTH-1:0] operand;
    } div_cmd_t;

    typedef struct packed {
        logic                   done;
        logic [VALUE_WIDTH-1:0] quotient;
        logic [DIGIT_W-1:0]     remainder;
    } div_stat_t;

endpackage

`default_nettype wire

/* rtl/irt_if.sv */
`default_nettype none

// Input channel: one signed value per transfer.
interface irt_in_if;
    import irt_pkg::*;
    logic                          valid;
    logic                          ready;
    logic signed [VALUE_WIDTH-1:0] number_in;

    modport source (output valid, output number_in, input ready);
    modport sink (input valid, input number_in, output ready);
endinterface

// Output channel: one character per transfer.
interface irt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] text_char;
    logic       last_char;

    modport source (output valid, output text_char, output last_char, input ready);
    modport sink (input valid, input text_char, input last_char, output ready);
endinterface

`default_nettype wire

/* rtl/integer_to_radix_text.sv */
// Operation: each digit takes one division on the shared 4-bit-per-cycle divider. The digits
// then come out one character per cycle while the output is not stalled.
// No new number is taken until the last character of the previous one is loaded into the
// output register; a minus sign adds one character, and -2147483648 in radix 2 is the worst case.
// Reset: registers take their reset values, then a symbol-set check runs over every symbol
// slot (and reruns after every register write) during which no input is taken.
`default_nettype none

module integer_to_radix_text (
    input  logic                        clk,
    input  logic                        rst_n,
    irt_in_if.sink                      in_ch,
    irt_out_if.source                   out_ch,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [irt_pkg::PADDR_W-1:0] paddr,
    input  logic [irt_pkg::PDATA_W-1:0] pwdata,
    output logic [irt_pkg::PDATA_W-1:0] prdata,
    output logic                        pready
);
    import irt_pkg::*;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_EMIT = 2'd2;

    cfg_t      cfg;
    chk_stat_t chk;
    div_cmd_t  div_cmd;
    div_stat_t div_stat;

    logic [1:0]                          state_reg;
    logic [1:0]                          state_next;
    logic                                neg_reg;
    logic                                neg_next;
    logic                                minus_reg;
    logic                                minus_next;
    logic [ND_W-1:0]                     nd_reg;
    logic [ND_W-1:0]                     nd_next;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  stack_reg;
    logic [MAX_DIGITS-1:0][DIGIT_W-1:0]  stack_next;
    logic                                out_valid_reg;
    logic                                out_valid_next;
    logic [7:0]                          out_char_reg;
    logic [7:0]                          out_char_next;
    logic                                out_last_reg;
    logic                                out_last_next;
    logic                                in_accept;
    logic                                out_free;
    logic                                load;
    logic [VALUE_WIDTH-1:0]              num_u;
    logic [VALUE_WIDTH-1:0]              mag_in;

    irt_cfg u_cfg (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    irt_sym_check u_sym_check (
        .clk   (clk),
        .rst_n (rst_n),
        .cfg   (cfg),
        .stat  (chk)
    );

    irt_div_unit u_div_unit (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (div_cmd),
        .radix (cfg.radix),
        .stat  (div_stat)
    );

    // Handshake and magnitude of the incoming value.
    assign in_ch.ready = (state_reg == S_IDLE) && !chk.busy;
    assign in_accept   = in_ch.valid && in_ch.ready;
    assign out_free    = !out_valid_reg || out_ch.ready;
    assign num_u       = VALUE_WIDTH'(in_ch.number_in);
    assign mag_in      = num_u[VALUE_WIDTH-1] ? ({VALUE_WIDTH{1'b0}} - num_u) : num_u;

    // Sequencer: divide repeatedly, stacking digits, then pop them out.
    always_comb
    begin
        state_next      = state_reg;
        neg_next        = neg_reg;
        minus_next      = minus_reg;
        nd_next         = nd_reg;
        stack_next      = stack_reg;
        div_cmd.start   = 1'b0;
        div_cmd.operand = mag_in;
        load            = 1'b0;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_accept && chk.set_ok)
                begin
                    div_cmd.start = 1'b1;
                    neg_next      = num_u[VALUE_WIDTH-1];
                    nd_next       = '0;
                    state_next    = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_stat.done)
                begin
                    stack_next = {stack_reg[MAX_DIGITS-2:0], div_stat.remainder};
                    nd_next    = nd_reg + ND_W'(1);
                    if (div_stat.quotient == {VALUE_WIDTH{1'b0}})
                    begin
                        minus_next = neg_reg;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        div_cmd.start   = 1'b1;
                        div_cmd.operand = div_stat.quotient;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    load = 1'b1;
                    if (minus_reg)
                    begin
                        out_char_next = CH_MINUS;
                        out_last_next = 1'b0;
                        minus_next    = 1'b0;
                    end
                    else
                    begin
                        out_char_next = cfg.syms[stack_reg[0]];
                        out_last_next = (nd_reg == ND_W'(1));
                        stack_next    = {{DIGIT_W{1'b0}}, stack_reg[MAX_DIGITS-1:1]};
                        nd_next       = nd_reg - ND_W'(1);
                        if (nd_reg == ND_W'(1))
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Output register: holds a character until its transfer.
    always_comb
    begin
        if (load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            neg_reg       <= 1'b0;
            minus_reg     <= 1'b0;
            nd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            neg_reg       <= neg_next;
            minus_reg     <= minus_next;
            nd_reg        <= nd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        stack_reg    <= stack_next;
        out_char_reg <= out_char_next;
        out_last_reg <= out_last_next;
    end

    assign out_ch.valid     = out_valid_reg;
    assign out_ch.text_char = out_char_reg;
    assign out_ch.last_char = out_last_reg;

    // Every remainder from the divider is a legal digit of the radix.
    a_rem_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DIV && div_stat.done) |-> (RADIX_W'(div_stat.remainder) < cfg.radix))
        else $error("divider remainder not below radix");

    // The digit stack never holds more digits than the value can have.
    a_stack_bound: assert property (@(posedge clk) disable iff (!rst_n)
        nd_reg <= ND_W'(MAX_DIGITS))
        else $error("digit stack overflow");

    // While emitting, at least one digit remains on the stack.
    a_emit_has_digit: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (nd_reg != '0))
        else $error("emitting with an empty digit stack");

    // A value taken while the symbol set is bad produces no characters.
    a_bad_set_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && !chk.set_ok) |=> (state_reg == S_IDLE && !div_stat.done))
        else $error("conversion started on an invalid symbol set");

endmodule

`default_nettype wire

/* rtl/irt_cfg.sv */
`default_nettype none

module irt_cfg (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [irt_pkg::PADDR_W-1:0]  paddr,
    input  logic [irt_pkg::PDATA_W-1:0]  pwdata,
    output logic [irt_pkg::PDATA_W-1:0]  prdata,
    output logic                         pready,
    output irt_pkg::cfg_t                cfg
);
    import irt_pkg::*;

    logic [RADIX_W-1:0]              radix_reg;
    logic [RADIX_W-1:0]              radix_next;
    logic [SYM_WORDS-1:0][63:0]      sym_words_reg;
    logic [SYM_WORDS-1:0][63:0]      sym_words_next;
    logic [REG_IDX_W-1:0]            reg_idx;
    logic                            wr_en;

    assign reg_idx = paddr[PADDR_W-1:ADDR_LSB];
    assign wr_en   = psel && penable && pwrite;
    assign pready  = 1'b1;

    // Register writes on the access cycle of a write transfer.
    always_comb
    begin
        radix_next     = radix_reg;
        sym_words_next = sym_words_reg;
        if (wr_en)
        begin
            unique case (reg_idx)
                REG_RADIX: radix_next        = pwdata[RADIX_W-1:0];
                REG_SYM0:  sym_words_next[0] = pwdata;
                REG_SYM1:  sym_words_next[1] = pwdata;
                REG_SYM2:  sym_words_next[2] = pwdata;
                REG_SYM3:  sym_words_next[3] = pwdata;
                default:   radix_next        = radix_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            radix_reg        <= RADIX_RESET;
            sym_words_reg[0] <= SYM0_RESET;
            sym_words_reg[1] <= SYM1_RESET;
            sym_words_reg[2] <= SYM2_RESET;
            sym_words_reg[3] <= SYM3_RESET;
        end
        else
        begin
            radix_reg     <= radix_next;
            sym_words_reg <= sym_words_next;
        end
    end

    // Read-back mux.
    always_comb
    begin
        unique case (reg_idx)
            REG_RADIX: prdata = {{(PDATA_W-RADIX_W){1'b0}}, radix_reg};
            REG_SYM0:  prdata = sym_words_reg[0];
            REG_SYM1:  prdata = sym_words_reg[1];
            REG_SYM2:  prdata = sym_words_reg[2];
            REG_SYM3:  prdata = sym_words_reg[3];
            default:   prdata = {PDATA_W{1'b0}};
        endcase
    end

    assign cfg.wr    = wr_en;
    assign cfg.radix = radix_reg;
    assign cfg.syms  = sym_table_t'(sym_words_reg);

endmodule

`default_nettype wire

/* rtl/irt_sym_check.sv */
`default_nettype none

module irt_sym_check (
    input  logic               clk,
    input  logic               rst_n,
    input  irt_pkg::cfg_t      cfg,
    output irt_pkg::chk_stat_t stat
);
    import irt_pkg::*;

    localparam int SYM_IDX_W = $clog2(SYM_SLOTS);

    logic                 busy_reg;
    logic                 busy_next;
    logic                 ok_reg;
    logic                 ok_next;
    logic [SYM_IDX_W-1:0] idx_reg;
    logic [SYM_IDX_W-1:0] idx_next;
    logic [7:0]           cur_sym;
    logic                 bad;
    logic                 range_ok;

    // One symbol per sweep cycle: no NUL or sign, and no match with any later symbol in use.
    always_comb
    begin
        cur_sym = cfg.syms[idx_reg];
        bad     = 1'b0;
        if (RADIX_W'(idx_reg) < cfg.radix)
        begin
            if (cur_sym == CH_NUL || cur_sym == CH_PLUS || cur_sym == CH_MINUS)
            begin
                bad = 1'b1;
            end
            for (int j = 0; j < SYM_SLOTS; j++)
            begin
                if (SYM_IDX_W'(j) > idx_reg && RADIX_W'(j) < cfg.radix &&
                    cfg.syms[j] == cur_sym)
                begin
                    bad = 1'b1;
                end
            end
        end
    end

    // Sweep control: a register write restarts the sweep.
    always_comb
    begin
        busy_next = busy_reg;
        ok_next   = ok_reg;
        idx_next  = idx_reg;
        if (cfg.wr)
        begin
            busy_next = 1'b1;
            ok_next   = 1'b1;
            idx_next  = '0;
        end
        else if (busy_reg)
        begin
            ok_next  = ok_reg && !bad;
            idx_next = idx_reg + SYM_IDX_W'(1);
            if (idx_reg == SYM_IDX_W'(SYM_SLOTS - 1))
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b1;
            ok_reg   <= 1'b1;
            idx_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            ok_reg   <= ok_next;
            idx_reg  <= idx_next;
        end
    end

    assign range_ok = (cfg.radix >= RADIX_W'(2)) && (cfg.radix <= RADIX_W'(RADIX_LIMIT));

    assign stat.busy   = busy_reg;
    assign stat.set_ok = ok_reg && range_ok;

endmodule

`default_nettype wire

/* rtl/irt_div_unit.sv */
`default_nettype none

module irt_div_unit (
    input  logic                        clk,
    input  logic                        rst_n,
    input  irt_pkg::div_cmd_t           cmd,
    input  logic [irt_pkg::RADIX_W-1:0] radix,
    output irt_pkg::div_stat_t          stat
);
    import irt_pkg::*;

    logic                   busy_reg;
    logic                   busy_next;
    logic                   done_reg;
    logic                   done_next;
    logic [DIV_CNT_W-1:0]   cnt_reg;
    logic [DIV_CNT_W-1:0]   cnt_next;
    logic [VALUE_WIDTH-1:0] mag_reg;
    logic [VALUE_WIDTH-1:0] mag_next;
    logic [RADIX_W-1:0]     rem_reg;
    logic [RADIX_W-1:0]     rem_next;
    logic [VALUE_WIDTH-1:0] step_mag;
    logic [RADIX_W-1:0]     step_rem;
    logic [RADIX_W:0]       trial;

    // Restoring division, DIV_BITS dividend bits per cycle. The dividend
    // register shifts left and collects quotient bits at its low end.
    always_comb
    begin
        step_rem = rem_reg;
        step_mag = mag_reg;
        trial    = '0;
        for (int s = 0; s < DIV_BITS; s++)
        begin
            trial    = {step_rem, step_mag[VALUE_WIDTH-1]};
            step_mag = {step_mag[VALUE_WIDTH-2:0], 1'b0};
            if (trial >= {1'b0, radix})
            begin
                trial       = trial - {1'b0, radix};
                step_mag[0] = 1'b1;
            end
            step_rem = trial[RADIX_W-1:0];
        end
    end

    // Sequencing of one division.
    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        mag_next  = mag_reg;
        rem_next  = rem_reg;
        if (cmd.start)
        begin
            busy_next = 1'b1;
            cnt_next  = DIV_CNT_W'(DIV_CYCLES);
            mag_next  = cmd.operand;
            rem_next  = '0;
        end
        else if (busy_reg)
        begin
            mag_next = step_mag;
            rem_next = step_rem;
            cnt_next = cnt_reg - DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        rem_reg <= rem_next;
    end

    assign stat.done      = done_reg;
    assign stat.quotient  = mag_reg;
    assign stat.remainder = rem_reg[DIGIT_W-1:0];

endmodule

`default_nettype wire

/* tb/integer_to_radix_text_tb.sv */
`timescale 1ns / 100ps

module integer_to_radix_text_tb;
    import irt_pkg::*;

    // Idle time that lets a number that yields no text finish before a register write.
    localparam int DRAIN_CYCLES = 400;
    localparam int RANDOM_TEXTS = 300;
    localparam int MAX_PHASES   = 60;

    // Addresses past the last register; writes there must change nothing.
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = REG_IDX_W'(5);
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = REG_IDX_W'(7);

    typedef struct packed {
        logic [7:0] code;
        logic       last;
    } char_slot_t;

    typedef enum logic [1:0] {ROW_CONFIG, ROW_TYPED, ROW_PREDICTED} row_kind_t;

    typedef enum logic [1:0] {SET_VALID, SET_BAD_CHAR, SET_REPEAT, SET_BAD_RADIX} set_kind_t;

    // Config rows use reg_idx and value; number rows take the low 32 bits of value and
    // ignore reg_idx. Typed rows carry their exact text, and "" means no text at all.
    typedef struct {
        row_kind_t              kind;
        logic [REG_IDX_W-1:0]   reg_idx;
        logic [63:0]            value;
        string                  text;
    } stim_row_t;

    stim_row_t directed_rows [47] = '{
        // The reset symbol set repeats '8', so nothing comes out.
        '{ROW_TYPED,     REG_RADIX, 64'sd5,           ""},
        '{ROW_TYPED,     REG_RADIX, -64'sd2147483648, ""},
        // Plain decimal digits.
        '{ROW_CONFIG,    REG_SYM0,  64'h3736_3534_3332_3130, ""},
        '{ROW_CONFIG,    REG_SYM1,  64'h0000_0000_0000_3938, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd0,           "0"},
        '{ROW_TYPED,     REG_RADIX, 64'sd2147483647,  "2147483647"},
        '{ROW_TYPED,     REG_RADIX, -64'sd2147483648, "-2147483648"},
        '{ROW_PREDICTED, REG_RADIX, 64'sd1234567,     ""},
        // Smallest radix gives the longest text.
        '{ROW_CONFIG,    REG_RADIX, 64'd2,            ""},
        '{ROW_PREDICTED, REG_RADIX, -64'sd2147483648, ""},
        '{ROW_PREDICTED, REG_RADIX, 64'sd2147483647,  ""},
        '{ROW_TYPED,     REG_RADIX, -64'sd1,          "-1"},
        // Full 32-symbol set "0-9A-V" at the largest radix.
        '{ROW_CONFIG,    REG_SYM1,  64'h4645_4443_4241_3938, ""},
        '{ROW_CONFIG,    REG_SYM2,  64'h4E4D_4C4B_4A49_4847, ""},
        '{ROW_CONFIG,    REG_SYM3,  64'h5655_5453_5251_504F, ""},
        '{ROW_CONFIG,    REG_RADIX, 64'd32,           ""},
        '{ROW_PREDICTED, REG_RADIX, -64'sd2147483648, ""},
        '{ROW_PREDICTED, REG_RADIX, 64'sd2147483647,  ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd31,          "V"},
        '{ROW_TYPED,     REG_RADIX, -64'sd32,         "-10"},
        // Radix out of range, above and below.
        '{ROW_CONFIG,    REG_RADIX, 64'd33,           ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd1,           ""},
        '{ROW_CONFIG,    REG_RADIX, 64'd63,           ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd1,           ""},
        '{ROW_CONFIG,    REG_RADIX, 64'd0,            ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd1,           ""},
        '{ROW_CONFIG,    REG_RADIX, 64'd1,            ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd0,           ""},
        // Hex, then a plus sign and a zero byte among the symbols in use.
        '{ROW_CONFIG,    REG_RADIX, 64'd16,           ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd255,         "FF"},
        '{ROW_CONFIG,    REG_SYM0,  64'h3736_3534_2B32_3130, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd255,         ""},
        '{ROW_CONFIG,    REG_SYM0,  64'h3736_3534_3300_3130, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd255,         ""},
        // A minus sign as symbol 15 spoils radix 16 but not radix 10.
        '{ROW_CONFIG,    REG_SYM0,  64'h3736_3534_3332_3130, ""},
        '{ROW_CONFIG,    REG_SYM1,  64'h2D45_4443_4241_3938, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd255,         ""},
        '{ROW_CONFIG,    REG_RADIX, 64'd10,           ""},
        '{ROW_TYPED,     REG_RADIX, -64'sd255,        "-255"},
        // Symbol 8 repeats symbol 0.
        '{ROW_CONFIG,    REG_SYM1,  64'h4645_4443_4241_3930, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd7,           ""},
        '{ROW_CONFIG,    REG_SYM1,  64'h4645_4443_4241_3938, ""},
        // Writes past the last register are dropped.
        '{ROW_CONFIG,    REG_SPARE_LO, 64'h2B2D_0000_2B2D_0000, ""},
        '{ROW_CONFIG,    REG_SPARE_HI, 64'hFFFF_FFFF_FFFF_FFFF, ""},
        '{ROW_TYPED,     REG_RADIX, 64'sd2147483647,  "2147483647"},
        // Only the low six bits of the radix register are kept.
        '{ROW_CONFIG,    REG_RADIX, 64'hFFFF_FFFF_FFFF_FFC3, ""},
        '{ROW_TYPED,     REG_RADIX, -64'sd7,          "-21"}
    };

    logic                 clk;
    logic                 rst_n;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [PADDR_W-1:0]   paddr;
    logic [PDATA_W-1:0]   pwdata;
    logic [PDATA_W-1:0]   prdata;
    logic                 pready;

    irt_in_if  in_ch ();
    irt_out_if out_ch ();

    // Local copy of the configuration and the characters still owed by the block.
    logic [RADIX_W-1:0] radix_reg;
    logic [63:0]        symbol_words [SYM_WORDS];
    char_slot_t         chars_due [$];

    bit calm;
    bit drain_needed;
    int failures;
    int numbers_sent;
    int numbers_with_text;
    int chars_checked;
    int register_writes;

    integer_to_radix_text i_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Hard stop in case the block hangs.
    initial
    begin
        #5_000_000;
        $display("FAIL");
        $finish;
    end

    function automatic logic [7:0] symbol_at(input int k);
        return symbol_words[k / 8][(k % 8) * 8 +: 8];
    endfunction

    // A symbol set is usable when the radix fits and its symbols are distinct,
    // nonzero and neither sign character.
    function automatic bit symbol_set_ok();
        int         n;
        logic [7:0] c;
        n = int'(radix_reg);
        if (n < 2 || n > RADIX_LIMIT)
            return 1'b0;
        for (int i = 0; i < n; i++)
        begin
            c = symbol_at(i);
            if (c == CH_NUL || c == CH_PLUS || c == CH_MINUS)
                return 1'b0;
            for (int j = i + 1; j < n; j++)
                if (symbol_at(j) == c)
                    return 1'b0;
        end
        return 1'b1;
    endfunction

    // Queues the text of one number and returns how many characters it has.
    function automatic int predict_text(input logic [31:0] num);
        logic [31:0] mag;
        logic [31:0] rdx;
        int          digit_val [32];
        int          nd;
        bit          neg;
        nd = 0;
        if (!symbol_set_ok())
            return 0;
        rdx = 32'(radix_reg);
        neg = num[31];
        // The most negative value maps to 2^31, which still fits unsigned.
        mag = neg ? -num : num;
        do
        begin
            digit_val[nd] = int'(mag % rdx);
            nd++;
            mag = mag / rdx;
        end
        while (mag != 0);
        if (neg)
            chars_due.push_back('{code: CH_MINUS, last: 1'b0});
        for (int i = nd - 1; i >= 0; i--)
            chars_due.push_back('{code: symbol_at(digit_val[i]), last: (i == 0)});
        return nd + int'(neg);
    endfunction

    function automatic int pick_gap();
        if ($urandom_range(0, 19) < 17)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic logic [31:0] pick_number();
        logic [31:0] corner_values [5] = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0000,
                                           32'hFFFF_FFFF, 32'h8000_0001};
        logic [31:0] v;
        int          sel;
        sel = $urandom_range(0, 3);
        case (sel)
            0:       v = $urandom;
            1:       v = $urandom_range(0, 40);
            2:       v = corner_values[$urandom_range(0, 4)];
            default: v = $urandom >> $urandom_range(0, 31);
        endcase
        if ((sel == 1 || sel == 3) && $urandom_range(0, 1) == 1)
            v = -v;
        return v;
    endfunction

    task automatic read_register(input logic [REG_IDX_W-1:0] idx, output logic [63:0] data);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= PADDR_W'(idx) << ADDR_LSB;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        data = prdata;
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Writes one register, mirrors it locally and, unless it is a spare address, reads it back.
    task automatic write_register(input logic [REG_IDX_W-1:0] idx, input logic [63:0] val);
        logic [63:0] rd;
        logic [63:0] want;
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= PADDR_W'(idx) << ADDR_LSB;
        pwdata  <= val;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        register_writes++;

        if (idx == REG_RADIX)
            radix_reg = val[RADIX_W-1:0];
        else if (idx <= REG_SYM3)
            symbol_words[idx - REG_SYM0] = val;

        if (idx <= REG_SYM3)
        begin
            want = (idx == REG_RADIX) ? 64'(radix_reg) : symbol_words[idx - REG_SYM0];
            read_register(idx, rd);
            if (rd !== want)
            begin
                $display("%0t: register %0d read back: expected %h, actual %h",
                         $time, idx, want, rd);
                failures++;
            end
        end
    endtask

    // Offers one number and, once the transfer happens, queues its text.
    task automatic send_number(input logic [31:0] num, input bit typed, input string txt);
        int produced;
        in_ch.valid     <= 1'b1;
        in_ch.number_in <= num;
        do
            @(posedge clk);
        while (!in_ch.ready);
        drain_needed = 1'b1;
        numbers_sent++;
        if (typed)
        begin
            for (int i = 0; i < txt.len(); i++)
                chars_due.push_back('{code: txt[i], last: (i == txt.len() - 1)});
            produced = txt.len();
        end
        else
            produced = predict_text(num);
        if (produced != 0)
            numbers_with_text++;
    endtask

    task automatic input_gap();
        int gap = 0;
        if (!calm && $urandom_range(0, 1) == 1)
            gap = pick_gap();
        if (gap > 0)
        begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Lets every owed character arrive and any textless number finish.
    task automatic wait_quiet();
        if (drain_needed)
        begin
            in_ch.valid <= 1'b0;
            while (chars_due.size() != 0)
                @(posedge clk);
            repeat (DRAIN_CYCLES) @(posedge clk);
            drain_needed = 1'b0;
        end
    endtask

    // Builds a random symbol set of the given kind and writes all registers.
    task automatic program_symbol_set(input set_kind_t kind);
        logic [7:0]  bad_chars [3] = '{CH_PLUS, CH_MINUS, CH_NUL};
        bit [255:0]  used;
        logic [63:0] words [SYM_WORDS];
        logic [63:0] radix_word;
        logic [7:0]  c;
        int          n;
        int          k;
        int          j;
        used = '0;
        n = $urandom_range(2, MAX_SYMBOLS);
        foreach (words[w])
            words[w] = {$urandom, $urandom};
        for (k = 0; k < n; k++)
        begin
            do
                c = 8'($urandom_range(1, 255));
            while (c == CH_PLUS || c == CH_MINUS || used[c]);
            used[c] = 1'b1;
            words[k / 8][(k % 8) * 8 +: 8] = c;
        end

        k = $urandom_range(0, n - 1);
        case (kind)
            SET_BAD_CHAR:
                words[k / 8][(k % 8) * 8 +: 8] = bad_chars[$urandom_range(0, 2)];
            SET_REPEAT:
            begin
                do
                    j = $urandom_range(0, n - 1);
                while (j == k);
                words[k / 8][(k % 8) * 8 +: 8] = words[j / 8][(j % 8) * 8 +: 8];
            end
            SET_BAD_RADIX:
                n = ($urandom_range(0, 1) == 1) ? $urandom_range(0, 1) : $urandom_range(33, 63);
            default:
                ;
        endcase

        // Upper bits of the radix word are junk that the block must drop.
        radix_word = {$urandom, $urandom};
        radix_word[RADIX_W-1:0] = RADIX_W'(n);
        for (int w = 0; w < SYM_WORDS; w++)
            write_register(REG_IDX_W'(REG_SYM0 + w), words[w]);
        write_register(REG_RADIX, radix_word);
        if ($urandom_range(0, 3) == 0)
            write_register(REG_IDX_W'($urandom_range(REG_SPARE_LO, REG_SPARE_HI)),
                           {$urandom, $urandom});
    endtask

    // Output side: accept characters with random stalls.
    initial
    begin
        out_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            out_ch.ready <= 1'b1;
            repeat ($urandom_range(1, 8)) @(posedge clk);
            if (!calm && $urandom_range(0, 1) == 1)
            begin
                out_ch.ready <= 1'b0;
                repeat (pick_gap()) @(posedge clk);
            end
        end
    end

    // Compare every character transfer with the oldest one still owed.
    always @(posedge clk)
    begin : check_chars
        char_slot_t want;
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            if (chars_due.size() == 0)
            begin
                $display("%0t: unexpected character: expected none, actual %h last %b",
                         $time, out_ch.text_char, out_ch.last_char);
                failures++;
            end
            else
            begin
                want = chars_due.pop_front();
                chars_checked++;
                if (out_ch.text_char !== want.code || out_ch.last_char !== want.last)
                begin
                    $display("%0t: character mismatch: expected %h last %b, actual %h last %b",
                             $time, want.code, want.last, out_ch.text_char, out_ch.last_char);
                    failures++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain and verdict.
    initial
    begin : run
        set_kind_t kind;
        int        text_goal;
        int        phase_items;

        rst_n           <= 1'b0;
        in_ch.valid     <= 1'b0;
        in_ch.number_in <= '0;
        psel            <= 1'b0;
        penable         <= 1'b0;
        pwrite          <= 1'b0;
        paddr           <= '0;
        pwdata          <= '0;
        calm         = 1'b0;
        drain_needed = 1'b0;
        failures          = 0;
        numbers_sent      = 0;
        numbers_with_text = 0;
        chars_checked     = 0;
        register_writes   = 0;
        radix_reg       = RADIX_RESET;
        symbol_words[0] = SYM0_RESET;
        symbol_words[1] = SYM1_RESET;
        symbol_words[2] = SYM2_RESET;
        symbol_words[3] = SYM3_RESET;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[r])
        begin
            if (directed_rows[r].kind == ROW_CONFIG)
            begin
                wait_quiet();
                write_register(directed_rows[r].reg_idx, directed_rows[r].value);
            end
            else
            begin
                send_number(directed_rows[r].value[31:0], directed_rows[r].kind == ROW_TYPED,
                            directed_rows[r].text);
                input_gap();
            end
        end

        // Random phases: mostly usable symbol sets, some broken ones.
        text_goal = numbers_with_text + RANDOM_TEXTS;
        for (int phase = 0; phase < MAX_PHASES && numbers_with_text < text_goal; phase++)
        begin
            case ($urandom_range(0, 9))
                7:       kind = SET_BAD_CHAR;
                8:       kind = SET_REPEAT;
                9:       kind = SET_BAD_RADIX;
                default: kind = SET_VALID;
            endcase
            calm = ($urandom_range(0, 3) == 0);
            wait_quiet();
            program_symbol_set(kind);
            phase_items = (kind == SET_VALID) ? 40 : 8;
            repeat (phase_items)
            begin
                send_number(pick_number(), 1'b0, "");
                input_gap();
            end
        end

        wait_quiet();
        $display("Converted %0d numbers (%0d with text) across %0d register writes.",
                 numbers_sent, numbers_with_text, register_writes);
        $display("Checked %0d characters; %0d failures.", chars_checked, failures);
        if (failures == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end

endmodule
